>>> sv/afs_pkg.sv
// Shared constants and types for the alignment flag statistics block.
`default_nettype none

package afs_pkg;

	localparam int COUNT_WIDTH  = 48;
	localparam int NUM_COUNTERS = 30;
	localparam int INDEX_WIDTH  = $clog2(NUM_COUNTERS);

	// Command codes
	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// Flag word bit positions
	localparam int FLAG_PROPER    = 1;
	localparam int FLAG_UNMAPPED  = 2;
	localparam int FLAG_MATE_UNMAP = 3;
	localparam int FLAG_READ1     = 6;
	localparam int FLAG_READ2     = 7;
	localparam int FLAG_SECONDARY = 8;
	localparam int FLAG_DUP       = 10;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef enum logic [INDEX_WIDTH-1:0] {
		C_R1, C_R2, C_SE, C_R1_MAP, C_R2_MAP, C_SE_MAP, C_R1_MAP_PP, C_R2_MAP_PP,
		C_R1_MAP_SEC, C_R2_MAP_SEC, C_UNMAP, C_UNMAP_ID, C_R1_UNMAP_ID,
		C_R2_UNMAP_ID, C_SE_UNMAP_ID, C_DUP_R1, C_DUP_R2, C_SAME, C_SAME_PP,
		C_CROSS, C_CROSS_PP, C_SINGLETON, C_SINGLETON_PP, C_UNMAP_PP,
		C_R1_UNMAP_ID_PP, C_R2_UNMAP_ID_PP, C_R1_UNMAP_NOID, C_R2_UNMAP_NOID,
		C_SE_UNMAP_NOID, C_ERROR
	} cnt_idx_t;

endpackage

`default_nettype wire

>>> sv/alignment_flag_statistics.sv
// Top level of the alignment flag statistics block: record classifier and counter bank.
`default_nettype none

// Alignment flag statistics. Each input word is either a record (flag word,
// reference id, mate reference id) or a read command for one of 30 counters.
// Every input word yields exactly one result word. Throughput is one word per
// clock unless result_stall holds the flow; each word passes the input register,
// then the result register. A record raises up to six saturating counters in
// the cycle it moves from the input register to the result register, so a read
// command that follows a record, even in the very next cycle, sees that record
// counted. Counters are 48 bits wide, reset to zero, and hold at their top
// value. A read of index 30 or 31 returns zero; record results carry a zero
// counter value. The error counter is never raised. Backpressure on the result
// side stalls the input side combinationally through item_stall.
module alignment_flag_statistics
	import afs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire logic                   command,
	input  wire logic [15:0]            flag_word,
	input  wire logic signed [31:0]     ref_id,
	input  wire logic signed [31:0]     mate_ref_id,
	input  wire logic [4:0]             counter_index,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output logic [COUNT_WIDTH-1:0]      counter_value,
	output logic                        listed,
	output logic                        cross_proper_tag
);

	// input register
	logic                    valid_s1;
	logic                    command_s1;
	logic [15:0]             flag_s1;
	logic [31:0]             ref_s1;
	logic [31:0]             mate_s1;
	logic [4:0]              index_s1;

	// result register
	logic                    result_valid_q;
	count_t                  value_q;
	logic                    listed_q;
	logic                    cross_q;

	count_t                  cnt_q [NUM_COUNTERS];

	logic                    advance;
	logic [NUM_COUNTERS-1:0] inc;
	logic                    listed_c;
	logic                    cross_c;
	count_t                  read_c;

	// pick the counter of the read class: first read wins if both bits set
	function automatic cnt_idx_t by_class(input logic r1, input logic r2,
		input cnt_idx_t a, input cnt_idx_t b, input cnt_idx_t c);
		if (r1)
			return a;
		else if (r2)
			return b;
		else
			return c;
	endfunction

	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	// classification
	always_comb begin
		logic proper, unmapped, mate_unmapped, r1, r2, secondary, dup, same;
		proper        = flag_s1[FLAG_PROPER];
		unmapped      = flag_s1[FLAG_UNMAPPED];
		mate_unmapped = flag_s1[FLAG_MATE_UNMAP];
		r1            = flag_s1[FLAG_READ1];
		r2            = !r1 && flag_s1[FLAG_READ2];
		secondary     = flag_s1[FLAG_SECONDARY];
		dup           = flag_s1[FLAG_DUP];
		same          = (mate_s1 == ref_s1);
		inc      = '0;
		listed_c = 1'b0;
		cross_c  = 1'b0;
		if (command_s1 == CMD_RECORD) begin
			if (ref_s1[31]) begin
				// no reference id: read class and no-id counters only
				inc[by_class(r1, r2, C_R1, C_R2, C_SE)] = 1'b1;
				inc[by_class(r1, r2, C_R1_UNMAP_NOID, C_R2_UNMAP_NOID,
					C_SE_UNMAP_NOID)] = 1'b1;
			end else begin
				inc[by_class(r1, r2, C_R1, C_R2, C_SE)] = 1'b1;
				if (!unmapped) begin
					inc[by_class(r1, r2, C_R1_MAP, C_R2_MAP, C_SE_MAP)] = 1'b1;
					if (r1 || r2) begin
						if (proper)
							inc[by_class(r1, r2, C_R1_MAP_PP, C_R2_MAP_PP, C_R2_MAP_PP)] = 1'b1;
						if (secondary)
							inc[by_class(r1, r2, C_R1_MAP_SEC, C_R2_MAP_SEC,
								C_R2_MAP_SEC)] = 1'b1;
					end
				end else begin
					inc[C_UNMAP]    = 1'b1;
					inc[C_UNMAP_ID] = 1'b1;
					inc[by_class(r1, r2, C_R1_UNMAP_ID, C_R2_UNMAP_ID,
						C_SE_UNMAP_ID)] = 1'b1;
				end

				if (dup) begin
					// duplicates replace pairing; single end counts nothing here
					if (r1)
						inc[C_DUP_R1] = 1'b1;
					else if (r2)
						inc[C_DUP_R2] = 1'b1;
				end else if (same || !mate_s1[31]) begin
					if (!unmapped && !mate_unmapped) begin
						inc[same ? C_SAME : C_CROSS] = 1'b1;
						if (proper) begin
							inc[same ? C_SAME_PP : C_CROSS_PP] = 1'b1;
							if (!same) begin
								listed_c = 1'b1;
								cross_c  = 1'b1;
							end
						end
					end else if (!unmapped) begin
						inc[C_SINGLETON] = 1'b1;
						if (proper)
							inc[C_SINGLETON_PP] = 1'b1;
					end else if (proper) begin
						listed_c        = 1'b1;
						inc[C_UNMAP_PP] = 1'b1;
						if (r1)
							inc[C_R1_UNMAP_ID_PP] = 1'b1;
						else if (r2)
							inc[C_R2_UNMAP_ID_PP] = 1'b1;
					end
				end else begin
					// mate has no id
					inc[C_SINGLETON] = 1'b1;
					if (!unmapped && mate_unmapped && proper)
						inc[C_SINGLETON_PP] = 1'b1;
				end
			end
		end
	end

	// counter read port
	always_comb begin
		read_c = '0;
		if (command_s1 == CMD_READ && index_s1 < NUM_COUNTERS[4:0])
			read_c = cnt_q[index_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			command_s1 <= command;
			flag_s1    <= flag_word;
			ref_s1     <= ref_id;
			mate_s1    <= mate_ref_id;
			index_s1   <= counter_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			value_q  <= read_c;
			listed_q <= listed_c;
			cross_q  <= cross_c;
		end
	end

	// saturating counter bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COUNTERS; i++)
				cnt_q[i] <= '0;
		end else if (advance) begin
			for (int i = 0; i < NUM_COUNTERS; i++)
				if (inc[i] && cnt_q[i] != {COUNT_WIDTH{1'b1}})
					cnt_q[i] <= cnt_q[i] + count_t'(1);
		end
	end

	assign result_valid     = result_valid_q;
	assign counter_value    = value_q;
	assign listed           = listed_q;
	assign cross_proper_tag = cross_q;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the alignment flag statistics block.
module tb_top;
	import afs_pkg::*;

	// One expected result word, as the block should return it.
	typedef struct {
		count_t value;
		logic   listed;
		logic   cross_tag;
	} result_word_t;

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_stall;
	logic                command;
	logic [15:0]         flag_word;
	logic signed [31:0]  ref_id;
	logic signed [31:0]  mate_ref_id;
	logic [4:0]          counter_index;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [COUNT_WIDTH-1:0] counter_value;
	logic                listed;
	logic                cross_proper_tag;

	// Shadow of the counter bank, kept in word acceptance order.
	count_t       tally [NUM_COUNTERS];
	result_word_t predicted_words [$];
	int           mismatches = 0;
	// When set, neither side idles.
	logic         steady;

	alignment_flag_statistics uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.command          (command),
		.flag_word        (flag_word),
		.ref_id           (ref_id),
		.mate_ref_id      (mate_ref_id),
		.counter_index    (counter_index),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.counter_value    (counter_value),
		.listed           (listed),
		.cross_proper_tag (cross_proper_tag)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic void bump(cnt_idx_t c);
		if (tally[c] != '1)
			tally[c] = tally[c] + 1'b1;
	endfunction

	// Classify one word, update the shadow bank, return the expected result.
	function automatic result_word_t classify_and_count(logic cmd, logic [15:0] fw,
			logic signed [31:0] rid, logic signed [31:0] mid, logic [4:0] idx);
		result_word_t res;
		logic proper, unmapped, mate_unmapped, r1, r2, secondary, dup, same;
		cnt_idx_t cls, cls_map, cls_unmap_id, cls_noid;
		res.value     = '0;
		res.listed    = 1'b0;
		res.cross_tag = 1'b0;
		proper        = fw[FLAG_PROPER];
		unmapped      = fw[FLAG_UNMAPPED];
		mate_unmapped = fw[FLAG_MATE_UNMAP];
		r1            = fw[FLAG_READ1];
		// both read bits set counts as first read
		r2            = !r1 && fw[FLAG_READ2];
		secondary     = fw[FLAG_SECONDARY];
		dup           = fw[FLAG_DUP];
		cls           = r1 ? C_R1 : (r2 ? C_R2 : C_SE);
		cls_map       = r1 ? C_R1_MAP : (r2 ? C_R2_MAP : C_SE_MAP);
		cls_unmap_id  = r1 ? C_R1_UNMAP_ID : (r2 ? C_R2_UNMAP_ID : C_SE_UNMAP_ID);
		cls_noid      = r1 ? C_R1_UNMAP_NOID : (r2 ? C_R2_UNMAP_NOID : C_SE_UNMAP_NOID);

		if (cmd == CMD_READ) begin
			if (idx < NUM_COUNTERS)
				res.value = tally[idx];
			return res;
		end

		// no reference id: read class and no-id counters only
		if (rid < 0) begin
			bump(cls);
			bump(cls_noid);
			return res;
		end

		if (!unmapped) begin
			bump(cls);
			bump(cls_map);
			if (r1 || r2) begin
				if (proper)
					bump(r1 ? C_R1_MAP_PP : C_R2_MAP_PP);
				if (secondary)
					bump(r1 ? C_R1_MAP_SEC : C_R2_MAP_SEC);
			end
		end else begin
			bump(C_UNMAP);
			bump(C_UNMAP_ID);
			bump(cls);
			bump(cls_unmap_id);
		end

		same = (mid == rid);
		if (dup) begin
			if (r1)
				bump(C_DUP_R1);
			else if (r2)
				bump(C_DUP_R2);
		end else if (same || mid >= 0) begin
			if (!unmapped && !mate_unmapped) begin
				bump(same ? C_SAME : C_CROSS);
				if (proper) begin
					bump(same ? C_SAME_PP : C_CROSS_PP);
					if (!same) begin
						res.listed    = 1'b1;
						res.cross_tag = 1'b1;
					end
				end
			end else if (!unmapped) begin
				bump(C_SINGLETON);
				if (proper)
					bump(C_SINGLETON_PP);
			end else if (proper) begin
				res.listed = 1'b1;
				bump(C_UNMAP_PP);
				if (r1)
					bump(C_R1_UNMAP_ID_PP);
				else if (r2)
					bump(C_R2_UNMAP_ID_PP);
			end
		end else begin
			// mate has no id
			bump(C_SINGLETON);
			if (!unmapped && mate_unmapped && proper)
				bump(C_SINGLETON_PP);
		end
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Drive one word from a falling edge, hold it until accepted, predict it.
	task automatic send_word(logic cmd, logic [15:0] fw, logic signed [31:0] rid,
			logic signed [31:0] mid, logic [4:0] idx);
		if (!steady) begin
			while ($urandom_range(0, 99) < 16) begin
				item_valid <= 1'b0;
				@(negedge clk);
			end
		end
		item_valid    <= 1'b1;
		command       <= cmd;
		flag_word     <= fw;
		ref_id        <= rid;
		mate_ref_id   <= mid;
		counter_index <= idx;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predicted_words.push_back(classify_and_count(cmd, fw, rid, mid, idx));
		@(negedge clk);
	endtask

	task automatic read_counter(logic [4:0] idx);
		send_word(CMD_READ, 16'($urandom), $urandom, $urandom, idx);
	endtask

	task automatic send_record(logic [15:0] fw, logic signed [31:0] rid,
			logic signed [31:0] mid);
		send_word(CMD_RECORD, fw, rid, mid, 5'($urandom));
	endtask

	// Result side backpressure.
	always @(negedge clk)
		result_stall <= arst_n && !steady && ($urandom_range(0, 99) < 16);

	// Result checker: in-order compare against the oldest prediction.
	always @(posedge clk) begin : check_results
		result_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (predicted_words.size() == 0) begin
				report_mismatch("result word with nothing outstanding");
			end else begin
				want = predicted_words.pop_front();
				if (counter_value !== want.value)
					report_mismatch($sformatf("counter_value %0h, want %0h",
						counter_value, want.value));
				if (listed !== want.listed)
					report_mismatch($sformatf("listed %b, want %b", listed, want.listed));
				if (cross_proper_tag !== want.cross_tag)
					report_mismatch($sformatf("cross_proper_tag %b, want %b",
						cross_proper_tag, want.cross_tag));
			end
		end
	end

	// Bank must be clear after reset; indices past the bank read zero.
	task automatic test_reset_state();
		read_counter(5'(C_R1));
		read_counter(5'(C_SAME));
		read_counter(5'(C_ERROR));
		read_counter(5'd30);
		read_counter(5'd31);
	endtask

	// Hand-picked records hitting each classification path.
	task automatic test_directed_records();
		send_record(16'h0000, 32'sd0, 32'sd0);              // single end, mapped, same
		send_record(16'hFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF); // all bits: r1 duplicate
		send_record(16'h0042, 32'sd1, 32'sd2);              // r1 proper cross, listed
		send_record(16'h0182, 32'sd5, 32'sd5);              // r2 proper secondary same
		send_record(16'h00C0, 32'sd0, 32'sd0);              // both read bits
		send_record(16'h0046, 32'sd3, 32'sd3);              // unmapped proper, listed
		send_record(16'h0086, 32'sd3, -32'sd1);             // unmapped, mate no id
		send_record(16'h004A, 32'sd2, 32'sd2);              // mate unmapped, proper
		send_record(16'h000A, 32'sd2, -32'sd1);             // no mate id, mate unmapped
		send_record(16'h0002, 32'sd2, -32'sd1);             // no mate id, mate mapped
		send_record(16'h0040, -32'sd1, 32'sd0);             // r1 without id
		send_record(16'h0482, -32'sd1, -32'sd1);            // r2 without id
		send_record(16'h0000, 32'sh80000000, 32'sd4);       // se without id
		send_record(16'h0400, 32'sd0, 32'sd0);              // se duplicate
		send_record(16'h0480, 32'sd0, 32'sd1);              // r2 duplicate
		send_record(16'h0000, 32'sd0, 32'sh7FFFFFFF);       // plain cross
		read_counter(5'(C_R1));
		read_counter(5'(C_CROSS_PP));
		read_counter(5'(C_SINGLETON_PP));
		read_counter(5'(C_ERROR));
	endtask

	// Mostly well-formed records with random content, some noise and reads.
	task automatic test_random_traffic(int n_words);
		logic [15:0] fw;
		logic signed [31:0] rid, mid;
		int k;
		for (int i = 0; i < n_words; i++) begin
			steady = (i >= 400 && i < 700);
			if ($urandom_range(0, 99) < 12) begin
				read_counter(5'($urandom_range(0, 31)));
				continue;
			end
			if ($urandom_range(0, 99) < 10) begin
				fw = 16'($urandom);
			end else begin
				fw = '0;
				k = $urandom_range(0, 19);
				fw[FLAG_READ1]      = (k < 8) || (k == 19);
				fw[FLAG_READ2]      = (k >= 8 && k < 16) || (k == 19);
				fw[FLAG_PROPER]     = 1'($urandom_range(0, 1));
				fw[FLAG_UNMAPPED]   = ($urandom_range(0, 3) == 0);
				fw[FLAG_MATE_UNMAP] = ($urandom_range(0, 3) == 0);
				fw[FLAG_SECONDARY]  = ($urandom_range(0, 4) == 0);
				fw[FLAG_DUP]        = ($urandom_range(0, 6) == 0);
			end
			k = $urandom_range(0, 99);
			if (k < 10)
				rid = -32'sd1;
			else if (k < 15)
				rid = $urandom;
			else
				rid = $urandom_range(0, 3);
			k = $urandom_range(0, 99);
			if (k < 15)
				mid = -32'sd1;
			else if (k < 20)
				mid = $urandom;
			else if (k < 60)
				mid = rid;
			else
				mid = $urandom_range(0, 3);
			send_record(fw, rid, mid);
		end
		steady = 1'b0;
	endtask

	// Read the whole index space back after the traffic.
	task automatic test_counter_readback();
		for (int i = 0; i < 32; i++)
			read_counter(5'(i));
	endtask

	initial begin
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		command       = CMD_RECORD;
		flag_word     = '0;
		ref_id        = '0;
		mate_ref_id   = '0;
		counter_index = '0;
		steady        = 1'b0;
		foreach (tally[i])
			tally[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_directed_records();
		test_random_traffic(1200);
		test_counter_readback();

		item_valid <= 1'b0;
		while (predicted_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
sv/afs_pkg.sv
sv/alignment_flag_statistics.sv
verif/tb_top.sv
